@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every clock edge outside reset.
`define SMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define SMT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

@@ rtl/smt_pkg.sv @@
// Types, constants and helper functions for the match thinning block.
// No dependencies.
package smt_pkg;

  localparam int unsigned MAX_KEPT_DEF = 1024;
  localparam int unsigned DIV_STEPS    = 30;
  localparam int unsigned CORDIC_ITERS = 15;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;

  localparam logic [1:0] OUT_KEPT   = 2'd0;
  localparam logic [1:0] OUT_CLOSE  = 2'd1;
  localparam logic [1:0] OUT_FULL   = 2'd2;

  localparam logic [14:0] WIDTH_RST  = 15'd4096;
  localparam logic [14:0] HEIGHT_RST = 15'd2048;
  localparam logic [16:0] TOL_RST    = 17'd1144;
  localparam logic [16:0] TOL_MAX    = 17'd102944;
  localparam logic [17:0] TOL_SCALE  = 18'd166886;

  typedef struct packed {
    logic [19:0] view1_x;
    logic [19:0] view1_y;
    logic [19:0] view2_x;
    logic [19:0] view2_y;
    logic [19:0] view3_x;
    logic [19:0] view3_y;
    logic        new_set;
  } in_t;

  typedef struct packed {
    logic [19:0] kept1_x;
    logic [19:0] kept1_y;
    logic [19:0] kept2_x;
    logic [19:0] kept2_y;
    logic [19:0] kept3_x;
    logic [19:0] kept3_y;
    logic [1:0]  outcome;
  } out_t;

  typedef struct packed {
    in_t                pay;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] ct;
    logic               tol_zero;
  } ent_t;

  // arctangent table in turn units (65536 per full turn)
  function automatic logic signed [17:0] atan_turn(input logic [3:0] i);
    logic signed [17:0] r;
    case (i)
      4'd0:    r = 18'sd8192;
      4'd1:    r = 18'sd4836;
      4'd2:    r = 18'sd2555;
      4'd3:    r = 18'sd1297;
      4'd4:    r = 18'sd651;
      4'd5:    r = 18'sd326;
      4'd6:    r = 18'sd163;
      4'd7:    r = 18'sd81;
      4'd8:    r = 18'sd41;
      4'd9:    r = 18'sd20;
      4'd10:   r = 18'sd10;
      4'd11:   r = 18'sd5;
      4'd12:   r = 18'sd3;
      4'd13:   r = 18'sd1;
      4'd14:   r = 18'sd1;
      default: r = 18'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_q15(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sd32767;
    else if (v < -18'sd32767) r = -16'sd32767;
    else r = v[15:0];
    return r;
  endfunction

endpackage

@@ rtl/smt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smt_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/smt_queue.sv @@
// Two-entry queue between the direction front end and the scan back end.
// Depends on smt_pkg.
module smt_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  smt_pkg::ent_t push_ent_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output smt_pkg::ent_t pop_ent_o
);

  smt_pkg::ent_t slot_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_ent_o    = slot_q[rp_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_ent_i;
    end
  end

endmodule

@@ rtl/smt_front.sv @@
// Front end: takes matches, divides pixels to phases, runs CORDIC, builds the direction.
// Depends on smt_pkg.
module smt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [14:0]   image_width_i,
  input  logic [14:0]   image_height_i,
  input  logic [16:0]   angle_tolerance_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  smt_pkg::in_t  in_i,
  output logic          q_valid_o,
  input  logic          q_ready_i,
  output smt_pkg::ent_t q_ent_o
);

  typedef enum logic [4:0] {
    F_IDLE   = 5'b00001,
    F_DIV    = 5'b00010,
    F_CORDIC = 5'b00100,
    F_MUL    = 5'b01000,
    F_PUSH   = 5'b10000
  } fstate_e;

  fstate_e state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic [1:0] sel_q, sel_d;

  smt_pkg::in_t pay_q, pay_d;
  logic [29:0] num_q, num_d;
  logic [15:0] quot_q, quot_d;
  logic [14:0] rem_q, rem_d, dvs_q, dvs_d;
  logic [15:0] lon_q, lon_d, lat_q, lat_d, tph_q, tph_d;
  logic signed [17:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic neg_q, neg_d, tolz_q, tolz_d;
  logic signed [15:0] cp_q, cp_d, sp_q, sp_d, cl_q, cl_d, sl_q, sl_d, ct_q, ct_d;
  logic signed [15:0] vx_q, vx_d, vy_q, vy_d;

  logic [15:0] r2, rsub, qn;
  logic        ge;
  logic [15:0] init_ph;
  logic signed [17:0] z0, iz, dx, dy, at, fx, fy;
  logic        ineg;
  logic [3:0]  sh;
  logic signed [15:0] mb;
  logic signed [31:0] mp;
  logic signed [32:0] ms;
  logic [16:0] tol_c;
  logic [35:0] tprod;

  assign r2   = {rem_q, num_q[29]};
  assign ge   = (r2 >= {1'b0, dvs_q});
  assign rsub = r2 - {1'b0, dvs_q};
  assign qn   = {quot_q[14:0], ge};

  assign init_ph = (state_q == F_DIV) ? lon_q : ((sel_q == 2'd0) ? lat_q : tph_q);
  assign z0 = 18'(signed'(init_ph));

  always_comb begin
    iz   = z0;
    ineg = 1'b0;
    if (z0 > 18'sd16384) begin
      iz   = z0 - 18'sd32768;
      ineg = 1'b1;
    end else if (z0 < -18'sd16384) begin
      iz   = z0 + 18'sd32768;
      ineg = 1'b1;
    end
  end

  assign sh = cnt_q[3:0];
  assign dx = cy_q >>> sh;
  assign dy = cx_q >>> sh;
  assign at = smt_pkg::atan_turn(sh);
  assign fx = neg_q ? -cx_q : cx_q;
  assign fy = neg_q ? -cy_q : cy_q;

  assign mb = cnt_q[0] ? sp_q : cp_q;
  assign mp = cl_q * mb;
  assign ms = 33'(mp) + 33'sd16384;

  assign tol_c = (angle_tolerance_i > smt_pkg::TOL_MAX) ? smt_pkg::TOL_MAX
                                                        : angle_tolerance_i;
  assign tprod = 36'(tol_c) * 36'(smt_pkg::TOL_SCALE) + 36'd524288;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    pay_d   = pay_q;
    num_d   = num_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    lon_d   = lon_q;
    lat_d   = lat_q;
    tph_d   = tph_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    cz_d    = cz_q;
    neg_d   = neg_q;
    tolz_d  = tolz_q;
    cp_d    = cp_q;
    sp_d    = sp_q;
    cl_d    = cl_q;
    sl_d    = sl_q;
    ct_d    = ct_q;
    vx_d    = vx_q;
    vy_d    = vy_q;
    unique case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          pay_d   = in_i;
          tolz_d  = (angle_tolerance_i == 17'd0);
          tph_d   = tprod[35:20];
          num_d   = {in_i.view2_x, 10'd0};
          dvs_d   = (image_width_i == 15'd0) ? 15'd1 : image_width_i;
          rem_d   = '0;
          quot_d  = '0;
          cnt_d   = '0;
          sel_d   = 2'd0;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        num_d  = {num_q[28:0], 1'b0};
        rem_d  = ge ? rsub[14:0] : r2[14:0];
        quot_d = qn;
        cnt_d  = cnt_q + 5'd1;
        if (cnt_q == 5'(smt_pkg::DIV_STEPS - 1)) begin
          cnt_d = '0;
          if (sel_q == 2'd0) begin
            lon_d  = qn;
            num_d  = {1'b0, pay_q.view2_y, 9'd0};
            dvs_d  = (image_height_i < 15'd2) ? 15'd1 : image_height_i - 15'd1;
            rem_d  = '0;
            quot_d = '0;
            sel_d  = 2'd1;
          end else begin
            lat_d   = qn - 16'd16384;
            cx_d    = 18'sd19898;
            cy_d    = '0;
            cz_d    = iz;
            neg_d   = ineg;
            sel_d   = 2'd0;
            state_d = F_CORDIC;
          end
        end
      end
      F_CORDIC: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q < 5'(smt_pkg::CORDIC_ITERS)) begin
          if (!cz_q[17]) begin
            cx_d = cx_q - dx;
            cy_d = cy_q + dy;
            cz_d = cz_q - at;
          end else begin
            cx_d = cx_q + dx;
            cy_d = cy_q - dy;
            cz_d = cz_q + at;
          end
        end else begin
          cnt_d = '0;
          case (sel_q)
            2'd0: begin
              cp_d = smt_pkg::clamp_q15(fx);
              sp_d = smt_pkg::clamp_q15(fy);
            end
            2'd1: begin
              cl_d = smt_pkg::clamp_q15(fx);
              sl_d = smt_pkg::clamp_q15(fy);
            end
            default: ct_d = smt_pkg::clamp_q15(fx);
          endcase
          if (sel_q == 2'd2) begin
            state_d = F_MUL;
          end else begin
            sel_d = sel_q + 2'd1;
            cx_d  = 18'sd19898;
            cy_d  = '0;
            cz_d  = iz;
            neg_d = ineg;
          end
        end
      end
      F_MUL: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q[0]) begin
          vy_d    = ms[30:15];
          state_d = F_PUSH;
        end else begin
          vx_d = ms[30:15];
        end
      end
      F_PUSH: begin
        if (q_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q  <= pay_d;
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    lon_q  <= lon_d;
    lat_q  <= lat_d;
    tph_q  <= tph_d;
    cx_q   <= cx_d;
    cy_q   <= cy_d;
    cz_q   <= cz_d;
    neg_q  <= neg_d;
    tolz_q <= tolz_d;
    cp_q   <= cp_d;
    sp_q   <= sp_d;
    cl_q   <= cl_d;
    sl_q   <= sl_d;
    ct_q   <= ct_d;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
  end

  assign in_ready_o = (state_q == F_IDLE);
  assign q_valid_o  = (state_q == F_PUSH);

  always_comb begin
    q_ent_o.pay      = pay_q;
    q_ent_o.vx       = vx_q;
    q_ent_o.vy       = vy_q;
    q_ent_o.vz       = sl_q;
    q_ent_o.ct       = ct_q;
    q_ent_o.tol_zero = tolz_q;
  end

endmodule

@@ rtl/smt_back.sv @@
// Back end: scans kept directions through a dot-product pipeline, decides, stores.
// Depends on smt_pkg; drives the direction store RAM.
module smt_back #(
  parameter int unsigned MAX_KEPT = smt_pkg::MAX_KEPT_DEF,
  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  localparam int unsigned CW = $clog2(MAX_KEPT + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  output logic          q_ready_o,
  input  smt_pkg::ent_t q_ent_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output smt_pkg::out_t out_o,
  output logic          ram_we_o,
  output logic [AW-1:0] ram_waddr_o,
  output logic [47:0]   ram_wdata_o,
  output logic          ram_re_o,
  output logic [AW-1:0] ram_raddr_o,
  input  logic [47:0]   ram_rdata_i
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_DONE = 3'b100
  } bstate_e;

  bstate_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, rd_q, rd_d;
  logic p1_q, p1_d, p2_q, p2_d, close_q, close_d, ov_q, ov_d;
  smt_pkg::ent_t ent_q, ent_d;
  smt_pkg::out_t res_q, res_d;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [33:0] dot, limit;
  logic issue, hit, full, load;

  assign issue = (state_q == B_SCAN) && !ent_q.tol_zero && (rd_q < count_q);
  assign dot   = 34'(px_q) + 34'(py_q) + 34'(pz_q);
  assign limit = 34'(ent_q.ct) <<< 15;
  assign hit   = p2_q && (dot > 34'sd0) && (dot > limit);
  assign full  = (count_q == CW'(MAX_KEPT));
  assign load  = (state_q == B_DONE) && (!ov_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    rd_d    = rd_q;
    p1_d    = issue;
    p2_d    = p1_q;
    close_d = close_q;
    ent_d   = ent_q;
    res_d   = res_q;
    ov_d    = (ov_q && !out_ready_i) || load;
    unique case (state_q)
      B_IDLE: begin
        if (q_valid_i) begin
          ent_d   = q_ent_i;
          rd_d    = '0;
          p1_d    = 1'b0;
          p2_d    = 1'b0;
          close_d = 1'b0;
          state_d = B_SCAN;
        end
      end
      B_SCAN: begin
        if (issue) begin
          rd_d = rd_q + CW'(1);
        end
        if (hit) begin
          close_d = 1'b1;
          state_d = B_DONE;
        end else if (!issue && !p1_q && !p2_q) begin
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (load) begin
          res_d.kept1_x = ent_q.pay.view1_x;
          res_d.kept1_y = ent_q.pay.view1_y;
          res_d.kept2_x = ent_q.pay.view2_x;
          res_d.kept2_y = ent_q.pay.view2_y;
          res_d.kept3_x = ent_q.pay.view3_x;
          res_d.kept3_y = ent_q.pay.view3_y;
          if (close_q) begin
            res_d.outcome = smt_pkg::OUT_CLOSE;
          end else if (full) begin
            res_d.outcome = smt_pkg::OUT_FULL;
          end else begin
            res_d.outcome = smt_pkg::OUT_KEPT;
            count_d       = count_q + CW'(1);
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    if ((state_q == B_IDLE) && q_valid_i && q_ent_i.pay.new_set) begin
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      count_q <= '0;
      rd_q    <= '0;
      p1_q    <= 1'b0;
      p2_q    <= 1'b0;
      close_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rd_q    <= rd_d;
      p1_q    <= p1_d;
      p2_q    <= p2_d;
      close_q <= close_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    res_q <= res_d;
    px_q  <= ent_q.vx * signed'(ram_rdata_i[47:32]);
    py_q  <= ent_q.vy * signed'(ram_rdata_i[31:16]);
    pz_q  <= ent_q.vz * signed'(ram_rdata_i[15:0]);
  end

  assign q_ready_o   = (state_q == B_IDLE);
  assign out_valid_o = ov_q;
  assign out_o       = res_q;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rd_q[AW-1:0];
  assign ram_we_o    = load && !close_q && !full;
  assign ram_waddr_o = count_q[AW-1:0];
  assign ram_wdata_o = {ent_q.vx, ent_q.vy, ent_q.vz};

endmodule

@@ rtl/spherical_match_thinning.sv @@
// Channel   Handshake                  Payload
// in        in_valid_i / in_ready_o    in_i  (smt_pkg::in_t)
// out       out_valid_o / out_ready_i  out_o (smt_pkg::out_t)
// cfg       cfg_we_i                   cfg_idx_i, cfg_data_i
// Front end: takes one item at a time through two 30-step dividers, three CORDIC runs and
// two multiplies, overlapped with the back end through a two-item queue.
// Back end: takes one item at a time and scans one stored direction per cycle
// through a three-stage read/multiply/compare pipeline.
// Reset clears control state and the kept count; the direction RAM needs no clearing.
// A stalled output holds the back end in its final state; the front keeps filling the queue.
`include "assert_macros.svh"

module spherical_match_thinning #(
  parameter int unsigned MAX_KEPT = smt_pkg::MAX_KEPT_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_idx_i,
  input  logic [16:0]   cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  smt_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output smt_pkg::out_t out_o
);

  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  logic [14:0] width_q, height_q;
  logic [16:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= smt_pkg::WIDTH_RST;
      height_q <= smt_pkg::HEIGHT_RST;
      tol_q    <= smt_pkg::TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        smt_pkg::REG_WIDTH:  width_q  <= cfg_data_i[14:0];
        smt_pkg::REG_HEIGHT: height_q <= cfg_data_i[14:0];
        smt_pkg::REG_TOL:    tol_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic          fq_valid, fq_ready, bq_valid, bq_ready;
  smt_pkg::ent_t fq_ent, bq_ent;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [47:0]   ram_wdata, ram_rdata;

  smt_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .image_width_i     (width_q),
    .image_height_i    (height_q),
    .angle_tolerance_i (tol_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_i              (in_i),
    .q_valid_o         (fq_valid),
    .q_ready_i         (fq_ready),
    .q_ent_o           (fq_ent)
  );

  smt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_ent_i   (fq_ent),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_ent_o    (bq_ent)
  );

  smt_back #(.MAX_KEPT(MAX_KEPT)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (bq_valid),
    .q_ready_o   (bq_ready),
    .q_ent_i     (bq_ent),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  smt_ram #(.WIDTH(48), .DEPTH(MAX_KEPT)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  `SMT_ASSERT(a_store_means_kept, ram_we |=> out_valid_o && out_o.outcome == smt_pkg::OUT_KEPT,
              "direction stored without a kept result")
  `SMT_ASSERT(a_front_busy, in_valid_i && in_ready_o |=> !in_ready_o,
              "front end took a second item while busy")
  `SMT_NEVER(a_no_store_on_pop, ram_we && bq_ready,
             "store write while back end is idle")

endmodule
